// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

    // Fixed field widths
    localparam int CFG_W = 7;
    localparam int POS_W = 6;
    localparam int WIN_W = 9;

    // Board side after reset
    localparam int RESET_SIDE = 30;
    localparam int MIN_SIDE   = 3;

    // Rule constants: birth on three, survival on two or three
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;
    localparam int         CENTRE_BIT    = 4;

    // One cell in flight between the window stage and the rule stage
    typedef struct packed {
        logic             valid;
        logic [WIN_W-1:0] window;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } lgs_stage_t;

endpackage

// ===== rtl/lgs_cell_if.sv =====
interface lgs_cell_if;
    logic valid;
    logic ready;
    logic cell_alive;

    modport source (output valid, output cell_alive, input ready);
    modport sink (input valid, input cell_alive, output ready);
endinterface

// ===== rtl/lgs_result_if.sv =====
interface lgs_result_if;
    logic                      valid;
    logic                      ready;
    logic                      next_alive;
    logic [lgs_pkg::POS_W-1:0] out_row;
    logic [lgs_pkg::POS_W-1:0] out_col;
    logic                      last_of_board;

    modport source (output valid, output next_alive, output out_row, output out_col,
                    output last_of_board, input ready);
    modport sink (input valid, input next_alive, input out_row, input out_col,
                  input last_of_board, output ready);
endinterface

// ===== rtl/lgs_cfg_if.sv =====
interface lgs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [lgs_pkg::CFG_W-1:0] board_side;

    modport source (output valid, output board_side, input ready);
    modport sink (input valid, input board_side, output ready);
endinterface

// ===== rtl/lgs_ram.sv =====
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lgs_window.sv =====
module lgs_window #(
    parameter int MAX_SIDE = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0]  cfg_side,
    input  logic                       in_valid,
    input  logic                       in_cell,
    output logic                       in_ready,
    output lgs_pkg::lgs_stage_t        stage,
    input  logic                       take
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int XW = (CW > lgs_pkg::POS_W) ? CW : lgs_pkg::POS_W;
    localparam logic [CW-1:0] RESET_LAST =
        CW'(((lgs_pkg::RESET_SIDE > MAX_SIDE) ? MAX_SIDE : lgs_pkg::RESET_SIDE) - 1);

    logic [CW-1:0]                row_reg, row_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [CW-1:0]                last_reg, last_next;
    logic [lgs_pkg::WIN_W-1:0]    window_reg;
    logic                         stage_valid_reg, stage_valid_next;
    logic [lgs_pkg::POS_W-1:0]    row_out_reg, col_out_reg;
    logic                         last_out_reg;
    logic                         accept;
    logic                         on_border;
    logic                         cell_live;
    logic [1:0]                   line_rd;
    logic [1:0]                   line_wr;
    logic [2:0]                   column;
    logic [XW-1:0]                row_ext, col_ext;

    assign in_ready = !stage_valid_reg || take;
    assign accept   = in_valid && in_ready;

    // Clamp the written side into the supported range, keep side minus one
    always_comb
    begin
        if (int'(cfg_side) < lgs_pkg::MIN_SIDE)
        begin
            last_next = CW'(lgs_pkg::MIN_SIDE - 1);
        end
        else if (int'(cfg_side) > MAX_SIDE)
        begin
            last_next = CW'(MAX_SIDE - 1);
        end
        else
        begin
            last_next = CW'(cfg_side - 7'd1);
        end
    end

    // Advance the raster position, restart it on a config write
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Force the border ring dead
    assign on_border = (row_reg == '0) || (col_reg == '0) ||
                       (row_reg == last_reg) || (col_reg == last_reg);
    assign cell_live = in_cell && !on_border;

    // Line stores: bit 0 is two rows up, bit 1 is one row up
    assign line_wr = {cell_live, line_rd[1]};
    assign column  = {cell_live, line_rd[1], line_rd[0]};

    // Read ahead at the next position so the data is ready for the next beat
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_SIDE)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (line_wr),
        .rd_addr (col_next),
        .rd_data (line_rd)
    );

    assign row_ext = XW'(row_reg) - XW'(1);
    assign col_ext = XW'(col_reg) - XW'(1);

    // Hold a stage entry until the rule stage takes it
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = (row_reg >= CW'(2)) && (col_reg >= CW'(2));
        end
        else if (take)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= '0;
            col_reg         <= '0;
            last_reg        <= RESET_LAST;
            stage_valid_reg <= 1'b0;
            window_reg      <= '0;
        end
        else
        begin
            row_reg         <= row_next;
            col_reg         <= col_next;
            stage_valid_reg <= stage_valid_next;
            if (cfg_we)
            begin
                last_reg <= last_next;
            end
            if (accept)
            begin
                window_reg <= {column, window_reg[lgs_pkg::WIN_W-1:3]};
            end
        end
    end

    // Position of the cell being reported
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_out_reg  <= row_ext[lgs_pkg::POS_W-1:0];
            col_out_reg  <= col_ext[lgs_pkg::POS_W-1:0];
            last_out_reg <= (row_reg == last_reg) && (col_reg == last_reg);
        end
    end

    assign stage.valid  = stage_valid_reg;
    assign stage.window = window_reg;
    assign stage.row    = row_out_reg;
    assign stage.col    = col_out_reg;
    assign stage.last   = last_out_reg;

endmodule

// ===== rtl/lgs_rule.sv =====
module lgs_rule (
    input  logic                clk,
    input  logic                rst_n,
    input  lgs_pkg::lgs_stage_t stage,
    output logic                take,
    lgs_result_if.source        result
);

    logic                      out_valid_reg;
    logic                      alive_reg;
    logic [lgs_pkg::POS_W-1:0] row_reg;
    logic [lgs_pkg::POS_W-1:0] col_reg;
    logic                      last_reg;
    logic [3:0]                neigh;
    logic                      centre;
    logic                      alive_next;

    // Count the eight neighbors around the centre
    always_comb
    begin
        neigh = '0;
        for (int i = 0; i < lgs_pkg::WIN_W; i++)
        begin
            if (i != lgs_pkg::CENTRE_BIT)
            begin
                neigh = neigh + {3'd0, stage.window[i]};
            end
        end
    end

    assign centre     = stage.window[lgs_pkg::CENTRE_BIT];
    assign alive_next = (neigh == lgs_pkg::BIRTH_COUNT) ||
                        ((neigh == lgs_pkg::SURVIVE_COUNT) && centre);

    assign take = stage.valid && (!out_valid_reg || result.ready);

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            alive_reg <= alive_next;
            row_reg   <= stage.row;
            col_reg   <= stage.col;
            last_reg  <= stage.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.next_alive    = alive_reg;
    assign result.out_row       = row_reg;
    assign result.out_col       = col_reg;
    assign result.last_of_board = last_reg;

endmodule

// ===== rtl/life_generation_step.sv =====
// Path: the input beat of the cell below and right of a reported cell passes the
//   window register, then the result register, before its result beat appears.
// Throughput: one cell per cycle when the result side is not stalled, set by the
//   line-store RAM's one write and one read per cycle; the rule is a nine-bit count between two registers.
// Reset: rst_n clears position counters, window and valid flags, board side 30.
//   Line-store contents are not cleared; they are overwritten before use.
module life_generation_step #(
    parameter int MAX_SIDE = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    lgs_cfg_if.sink       cfg,
    lgs_cell_if.sink      cell_in,
    lgs_result_if.source  result
);

    lgs_pkg::lgs_stage_t stage;
    logic                take;
    logic                cfg_we;

    // Config writes land at once
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    lgs_window #(
        .MAX_SIDE (MAX_SIDE)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_side (cfg.board_side),
        .in_valid (cell_in.valid),
        .in_cell  (cell_in.cell_alive),
        .in_ready (cell_in.ready),
        .stage    (stage),
        .take     (take)
    );

    lgs_rule u_rule (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .result (result)
    );

endmodule

// ===== rtl/lgs_checker.sv =====
module lgs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_alive,
    input logic [lgs_pkg::POS_W-1:0] res_row,
    input logic [lgs_pkg::POS_W-1:0] res_col,
    input logic                      res_last
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_alive) &&
        $stable(res_row) && $stable(res_col) && $stable(res_last))
        else $error("result beat changed while stalled");

    // Reported cells are interior, never on row or column zero
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_row != '0) && (res_col != '0))
        else $error("border cell reported");

    // The final cell of a square board sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last |-> res_row == res_col)
        else $error("last cell off the diagonal");

endmodule

bind life_generation_step lgs_checker u_lgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_alive (result.next_alive),
    .res_row   (result.out_row),
    .res_col   (result.out_col),
    .res_last  (result.last_of_board)
);

// ===== test/life_generation_step_test.sv =====
module life_generation_step_test;

    localparam int MAX_SIDE    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CELLS = 60;

    // One expected or observed result beat
    typedef struct packed {
        logic                      alive;
        logic [lgs_pkg::POS_W-1:0] row;
        logic [lgs_pkg::POS_W-1:0] col;
        logic                      last;
    } life_result_t;

    // Tracks the board the way the block should and holds the pending next states
    class life_tracker;
        bit [lgs_pkg::CFG_W-1:0] side_reg;
        bit                      upper_line [MAX_SIDE];
        bit                      middle_line [MAX_SIDE];
        bit [lgs_pkg::WIN_W-1:0] window;
        int unsigned             row;
        int unsigned             col;
        life_result_t            pending_states [$];
        int                      errors;

        function new();
            side_reg = lgs_pkg::RESET_SIDE;
            window   = '0;
            row      = 0;
            col      = 0;
            errors   = 0;
            foreach (upper_line[i]) upper_line[i] = 1'b0;
            foreach (middle_line[i]) middle_line[i] = 1'b0;
        endfunction

        // Clamp the programmed side into the supported range
        function int unsigned side_in_use();
            if (side_reg < lgs_pkg::MIN_SIDE)
                return lgs_pkg::MIN_SIDE;
            if (side_reg > MAX_SIDE)
                return MAX_SIDE;
            return side_reg;
        endfunction

        // A side write restarts the frame at cell (0,0)
        function void restart(bit [lgs_pkg::CFG_W-1:0] value);
            side_reg = value;
            row = 0;
            col = 0;
        endfunction

        // Shift one cell into the window and queue the next state it completes
        function void absorb_cell(bit alive);
            int unsigned  s;
            int unsigned  r;
            int unsigned  c;
            bit           cell_bit;
            bit           centre;
            int unsigned  neigh;
            life_result_t exp;
            s = side_in_use();
            r = row;
            c = col;
            cell_bit = alive;
            if (r >= s || c >= s) begin
                r = 0;
                c = 0;
            end
            // border ring always counts as dead
            if (r == 0 || c == 0 || r == s - 1 || c == s - 1)
                cell_bit = 1'b0;
            window = {cell_bit, middle_line[c], upper_line[c],
                      window[lgs_pkg::WIN_W-1:3]};
            upper_line[c]  = middle_line[c];
            middle_line[c] = cell_bit;
            if (r >= 2 && c >= 2) begin
                centre = window[lgs_pkg::CENTRE_BIT];
                neigh  = $countones(window) - centre;
                exp.alive = (neigh == 3) || (neigh == 2 && centre);
                exp.row   = lgs_pkg::POS_W'(r - 1);
                exp.col   = lgs_pkg::POS_W'(c - 1);
                exp.last  = (r == s - 1) && (c == s - 1);
                pending_states.push_back(exp);
            end
            c++;
            if (c >= s) begin
                c = 0;
                r++;
                if (r >= s)
                    r = 0;
            end
            row = r;
            col = c;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Match a result beat against the oldest pending next state
        task compare_result(life_result_t got);
            life_result_t exp;
            if (pending_states.size() == 0) begin
                report($sformatf("result beat at (%0d,%0d) with nothing pending",
                                 got.row, got.col));
                return;
            end
            exp = pending_states.pop_front();
            if (got.alive !== exp.alive)
                report($sformatf("next_alive at (%0d,%0d): got %b, want %b",
                                 exp.row, exp.col, got.alive, exp.alive));
            if (got.row !== exp.row)
                report($sformatf("out_row: got %0d, want %0d", got.row, exp.row));
            if (got.col !== exp.col)
                report($sformatf("out_col: got %0d, want %0d", got.col, exp.col));
            if (got.last !== exp.last)
                report($sformatf("last_of_board at (%0d,%0d): got %b, want %b",
                                 exp.row, exp.col, got.last, exp.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lgs_cfg_if    cfg_bus ();
    lgs_cell_if   cell_bus ();
    lgs_result_if res_bus ();

    life_generation_step #(.MAX_SIDE(MAX_SIDE)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .cell_in (cell_bus),
        .result  (res_bus)
    );

    life_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive result ready: random stalls, forced low during a hold-off
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count down a receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Watch all three channels at the rising edge
    always @(posedge clk)
    begin : watch_beats
        life_result_t got;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                got.alive = res_bus.next_alive;
                got.row   = res_bus.out_row;
                got.col   = res_bus.out_col;
                got.last  = res_bus.last_of_board;
                tracker.compare_result(got);
            end
            if (cell_bus.valid && cell_bus.ready)
                tracker.absorb_cell(cell_bus.cell_alive);
            if (cfg_bus.valid && cfg_bus.ready)
                tracker.restart(cfg_bus.board_side);
        end
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("life_generation_step_test: done, errors");
        $finish;
    end

    task automatic set_phase(input int k);
        case (k % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    // Offer one cell beat, idling first at random
    task automatic send_cell(input bit alive);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cell_bus.valid <= 1'b0;
        end
        @(negedge clk);
        cell_bus.valid      <= 1'b1;
        cell_bus.cell_alive <= alive;
        do @(posedge clk); while (!cell_bus.ready);
    endtask

    // Stream cells with a given percentage alive
    task automatic stream_cells(input int count, input int density);
        for (int i = 0; i < count; i++)
            send_cell($urandom_range(99) < density);
    endtask

    // Drop valid, drain the pending states, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        cell_bus.valid <= 1'b0;
        while (tracker.pending_states.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_side(input bit [lgs_pkg::CFG_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.board_side <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int cells;
        int shape;
        int done_cells;
        int k;
        int dens;
        bit [lgs_pkg::CFG_W-1:0] value;

        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.board_side  = '0;
        cell_bus.valid      = 1'b0;
        cell_bus.cell_alive = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset side: a few rows of a default board, then a restart
        set_phase(0);
        stream_cells(95, 50);

        // Side below range acts as three; border ignored, lone center dies
        write_side(lgs_pkg::CFG_W'(0));
        stream_cells(9, 100);
        // back-to-back board exercises the frame wrap
        stream_cells(9, 100);

        // Blinker on a five board with every border cell alive
        write_side(lgs_pkg::CFG_W'(5));
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_cell(r == 0 || c == 0 || r == 4 || c == 4 || r == 2);

        // Abandon a board midway and restart at the same side
        write_side(lgs_pkg::CFG_W'(4));
        stream_cells(7, 100);
        write_side(lgs_pkg::CFG_W'(4));
        stream_cells(16, 60);

        // Random boards, mostly small
        done_cells = 0;
        k = 0;
        while (done_cells < RANDOM_CELLS)
        begin
            set_phase(k);
            case ($urandom_range(9))
                0: value = lgs_pkg::CFG_W'($urandom_range(0, 2));
                1: value = lgs_pkg::CFG_W'($urandom_range(10, 16));
                default: value = lgs_pkg::CFG_W'($urandom_range(3, 9));
            endcase
            write_side(value);
            cells = tracker.side_in_use() * tracker.side_in_use();
            dens  = $urandom_range(0, 100);
            shape = $urandom_range(5);
            if (shape == 0)
                cells = $urandom_range(1, cells - 1);
            else if (shape == 1)
                cells = 2 * cells;
            // keep the random share of the run near its budget
            if (cells > RANDOM_CELLS - done_cells)
                cells = RANDOM_CELLS - done_cells;
            stream_cells(cells, dens);
            done_cells += cells;
            k++;
        end

        // Side above range acts as the largest; receiver holds off for a long stretch
        set_phase(0);
        write_side(7'h7F);
        hold_left = 600;
        stream_cells(3 * MAX_SIDE + 4, 40);

        set_phase(0);
        settle();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("life_generation_step_test: done, clean");
        else
            $display("life_generation_step_test: done, errors");
        $finish;
    end

endmodule

// ===== life_generation_step.f =====
rtl/lgs_pkg.sv
rtl/lgs_cell_if.sv
rtl/lgs_result_if.sv
rtl/lgs_cfg_if.sv
rtl/lgs_ram.sv
rtl/lgs_window.sv
rtl/lgs_rule.sv
rtl/life_generation_step.sv
rtl/lgs_checker.sv
test/life_generation_step_test.sv
